[design/k_way_merge_reduce_core_assert.svh]
// Assertion macros shared by the merge-reduce block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef K_WAY_MERGE_REDUCE_CORE_ASSERT_SVH
`define K_WAY_MERGE_REDUCE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KWMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KWMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kwmr_pkg.sv]
// Shared types and codes of the k-way merge-reduce block.
// No dependencies.
package kwmr_pkg;

  localparam int SRC_W      = 4;
  localparam int FIELD_W    = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int SIU_W      = 5;
  localparam int ROP_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCES_IN_USE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_OP      = 8'd1;

  // reduce operations
  localparam logic [ROP_W-1:0] ROP_ADD = 2'd0;
  localparam logic [ROP_W-1:0] ROP_MIN = 2'd1;
  localparam logic [ROP_W-1:0] ROP_MAX = 2'd2;
  localparam logic [ROP_W-1:0] ROP_OR  = 2'd3;

  // request opcodes
  localparam logic OP_PAIR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [SIU_W-1:0] SIU_RESET = 5'd2;

  typedef struct packed {
    logic               opcode;
    logic [SRC_W-1:0]   source;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               refill_valid;
    logic [SRC_W-1:0]   refill_source;
    logic               pair_valid;
    logic [FIELD_W-1:0] pair_key;
    logic [FIELD_W-1:0] pair_value;
    logic               pair_last;
    logic               order_error;
  } out_item_t;

endpackage

[design/k_way_merge_reduce_core.sv]
// Top level of the k-way merge-reduce block: input register, head store,
// pending pair, config registers and result register.
// Depends on kwmr_pkg, kwmr_argmin, kwmr_reduce and the assertion header.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_opcode in_source in_key in_value
//   out      out_valid / out_ready refill, pair and error fields
//   cfg      cfg_valid / cfg_ready cfg_index cfg_wdata
//
// One request per cycle while the result register is free or being taken; a request
// waits in the input register and is then processed into the result register.
// Each request makes exactly one result. The rate is set by the head update, the
// argmin tree and the pending fold all being combinational between the input
// and result registers. Reset clears valid bits, end marks and the pending flag
// at once. A full result register stalls processing; the input register
// still holds one request meanwhile. Config writes are always taken.
`include "k_way_merge_reduce_core_assert.svh"

module k_way_merge_reduce_core
  import kwmr_pkg::*;
#(
  parameter int SOURCES     = 16,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [SRC_W-1:0]      in_source,
  input  logic [FIELD_W-1:0]    in_key,
  input  logic [FIELD_W-1:0]    in_value,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_refill_valid,
  output logic [SRC_W-1:0]      out_refill_source,
  output logic                  out_pair_valid,
  output logic [FIELD_W-1:0]    out_pair_key,
  output logic [FIELD_W-1:0]    out_pair_value,
  output logic                  out_pair_last,
  output logic                  out_order_error,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW = KEY_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  // config
  logic [SIU_W-1:0] siu_r;
  logic [ROP_W-1:0] rop_r;

  // input and result registers
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r, out_item_nxt;
  logic      proc_fire;

  // head store
  logic [KW-1:0]      head_key_r [SOURCES];
  logic [VW-1:0]      head_val_r [SOURCES];
  logic [SOURCES-1:0] head_vld_r, head_vld_nxt;
  logic [SOURCES-1:0] ended_r, ended_nxt;

  // pending pair
  logic [KW-1:0] pend_key_r, pend_key_nxt;
  logic [VW-1:0] pend_val_r, pend_val_nxt;
  logic          pend_vld_r, pend_vld_nxt;

  // step logic
  logic [SOURCES-1:0] live, hit, dlv_wr, head_vld_eff, ended_eff, cand;
  logic [KW-1:0]      key_eff [SOURCES];
  logic [VW-1:0]      val_eff [SOURCES];
  logic               all_ready, any_head, take, fold, emit_take, emit_last;
  logic [SW-1:0]      t_idx;
  logic [KW-1:0]      t_key;
  logic [VW-1:0]      t_val;
  logic [VW-1:0]      fold_val;

  assign cfg_ready = 1'b1;
  assign proc_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= SIU_RESET;
      rop_r <= ROP_ADD;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SOURCES_IN_USE) siu_r <= cfg_wdata[SIU_W-1:0];
      else if (cfg_index == CFG_REDUCE_OP) rop_r <= cfg_wdata[ROP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r.opcode <= in_opcode;
      in_item_r.source <= in_source;
      in_item_r.key    <= in_key;
      in_item_r.value  <= in_value;
    end
  end

  // fold the current request into the heads before the take check
  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      live[i]         = (i == 0) || (i < int'(siu_r));
      hit[i]          = in_vld_r && live[i] && (int'(in_item_r.source) == i);
      dlv_wr[i]       = hit[i] && (in_item_r.opcode == OP_PAIR) && !ended_r[i] &&
                        !head_vld_r[i];
      ended_eff[i]    = ended_r[i] || (hit[i] && (in_item_r.opcode == OP_END));
      head_vld_eff[i] = head_vld_r[i] || dlv_wr[i];
      key_eff[i]      = dlv_wr[i] ? in_item_r.key[KW-1:0] : head_key_r[i];
      val_eff[i]      = dlv_wr[i] ? in_item_r.value[VW-1:0] : head_val_r[i];
      cand[i]         = live[i] && head_vld_eff[i];
    end
    all_ready = &(~live | head_vld_eff | ended_eff);
  end

  kwmr_argmin #(
    .SOURCES (SOURCES),
    .KW      (KW),
    .VW      (VW),
    .SW      (SW)
  ) u_argmin (
    .vld_i (cand),
    .key_i (key_eff),
    .val_i (val_eff),
    .any_o (any_head),
    .idx_o (t_idx),
    .key_o (t_key),
    .val_o (t_val)
  );

  kwmr_reduce #(
    .VW (VW)
  ) u_reduce (
    .op_i (rop_r),
    .a_i  (pend_val_r),
    .b_i  (t_val),
    .y_o  (fold_val)
  );

  always_comb begin
    take      = all_ready && any_head;
    fold      = take && pend_vld_r && (t_key == pend_key_r);
    emit_take = take && pend_vld_r && !fold;
    emit_last = all_ready && !any_head && pend_vld_r;

    ended_nxt = ended_eff;
    for (int i = 0; i < SOURCES; i++) begin
      head_vld_nxt[i] = head_vld_eff[i] && !(take && (int'(t_idx) == i));
    end

    pend_key_nxt = pend_key_r;
    pend_val_nxt = pend_val_r;
    pend_vld_nxt = pend_vld_r;
    if (fold) begin
      pend_val_nxt = fold_val;
    end else if (take) begin
      pend_key_nxt = t_key;
      pend_val_nxt = t_val;
      pend_vld_nxt = 1'b1;
    end else if (emit_last) begin
      pend_vld_nxt = 1'b0;
    end

    out_item_nxt               = '0;
    out_item_nxt.refill_valid  = take && !ended_eff[t_idx];
    out_item_nxt.refill_source = out_item_nxt.refill_valid ? SRC_W'(t_idx) : '0;
    out_item_nxt.pair_valid    = emit_take || emit_last;
    if (out_item_nxt.pair_valid) begin
      out_item_nxt.pair_key   = FIELD_W'(pend_key_r);
      out_item_nxt.pair_value = FIELD_W'(pend_val_r);
    end
    out_item_nxt.pair_last   = emit_last;
    out_item_nxt.order_error = emit_take && (t_key < pend_key_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
      ended_r    <= '0;
      pend_vld_r <= 1'b0;
    end else if (proc_fire) begin
      head_vld_r <= head_vld_nxt;
      ended_r    <= ended_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      pend_key_r <= pend_key_nxt;
      pend_val_r <= pend_val_nxt;
      for (int i = 0; i < SOURCES; i++) begin
        if (dlv_wr[i]) begin
          head_key_r[i] <= key_eff[i];
          head_val_r[i] <= val_eff[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) out_item_r <= out_item_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_refill_valid  = out_item_r.refill_valid;
  assign out_refill_source = out_item_r.refill_source;
  assign out_pair_valid    = out_item_r.pair_valid;
  assign out_pair_key      = out_item_r.pair_key;
  assign out_pair_value    = out_item_r.pair_value;
  assign out_pair_last     = out_item_r.pair_last;
  assign out_order_error   = out_item_r.order_error;

  `KWMR_ASSERT_NOW(a_last_is_clean, out_valid && out_pair_last,
                   out_pair_valid && !out_order_error && !out_refill_valid,
                   "last pair carries a refill or error")
  `KWMR_ASSERT_NOW(a_idle_pair_zero, out_valid && !out_pair_valid,
                   (out_pair_key == '0) && (out_pair_value == '0) && !out_pair_last &&
                   !out_order_error, "idle pair fields not zero")
  `KWMR_ASSERT_NEXT(a_last_drains, proc_fire && emit_last,
                    !pend_vld_r && out_valid && out_pair_last, "pending pair kept after last")
  `KWMR_ASSERT_NEXT(a_fold_no_emit, proc_fire && fold, out_valid && !out_pair_valid,
                    "folded pair was emitted")

endmodule

[design/kwmr_argmin.sv]
// Comparator tree that finds the smallest valid head key, lowest index on ties.
// Depends on nothing but its parameters.
module kwmr_argmin #(
  parameter int SOURCES = 16,
  parameter int KW      = 64,
  parameter int VW      = 64,
  parameter int SW      = 4
) (
  input  logic [SOURCES-1:0] vld_i,
  input  logic [KW-1:0]      key_i [SOURCES],
  input  logic [VW-1:0]      val_i [SOURCES],
  output logic               any_o,
  output logic [SW-1:0]      idx_o,
  output logic [KW-1:0]      key_o,
  output logic [VW-1:0]      val_o
);

  localparam int LVLS = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int NP   = 1 << LVLS;
  localparam int NN   = 2 * NP - 1;

  logic          nvld [NN];
  logic [SW-1:0] nidx [NN];
  logic [KW-1:0] nkey [NN];
  logic [VW-1:0] nval [NN];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < SOURCES) begin : g_used
      assign nvld[NP-1+i] = vld_i[i];
      assign nidx[NP-1+i] = SW'(i);
      assign nkey[NP-1+i] = key_i[i];
      assign nval[NP-1+i] = val_i[i];
    end else begin : g_pad
      assign nvld[NP-1+i] = 1'b0;
      assign nidx[NP-1+i] = '0;
      assign nkey[NP-1+i] = '0;
      assign nval[NP-1+i] = '0;
    end
  end

  // left child always covers lower indexes, so it wins ties
  for (genvar j = 0; j < NP - 1; j++) begin : g_node
    logic pick_l;
    assign pick_l  = nvld[2*j+1] && (!nvld[2*j+2] || (nkey[2*j+1] <= nkey[2*j+2]));
    assign nvld[j] = nvld[2*j+1] || nvld[2*j+2];
    assign nidx[j] = pick_l ? nidx[2*j+1] : nidx[2*j+2];
    assign nkey[j] = pick_l ? nkey[2*j+1] : nkey[2*j+2];
    assign nval[j] = pick_l ? nval[2*j+1] : nval[2*j+2];
  end

  assign any_o = nvld[0];
  assign idx_o = nidx[0];
  assign key_o = nkey[0];
  assign val_o = nval[0];

endmodule

[design/kwmr_reduce.sv]
// Value combiner for equal keys: wrapping add, min, max or bitwise or.
// Depends on kwmr_pkg for the operation codes.
module kwmr_reduce
  import kwmr_pkg::*;
#(
  parameter int VW = 64
) (
  input  logic [ROP_W-1:0] op_i,
  input  logic [VW-1:0]    a_i,
  input  logic [VW-1:0]    b_i,
  output logic [VW-1:0]    y_o
);

  always_comb begin
    case (op_i)
      ROP_ADD: y_o = a_i + b_i;
      ROP_MIN: y_o = (a_i < b_i) ? a_i : b_i;
      ROP_MAX: y_o = (a_i > b_i) ? a_i : b_i;
      ROP_OR:  y_o = a_i | b_i;
      default: y_o = a_i | b_i;
    endcase
  end

endmodule

[tb/tb_k_way_merge_reduce_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for k_way_merge_reduce_core: directed table, then random merge streams.
// Depends on kwmr_pkg and the core; carries its own model of the merge and fold.
module tb_k_way_merge_reduce_core;
  import kwmr_pkg::*;

  localparam int NSRC = 16;
  localparam int PHASE_ITEMS = 170;
  localparam logic [FIELD_W-1:0] KMAX = '1;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // config rows carry their write data in the low bits of key
  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic               opcode;
    logic [SRC_W-1:0]   source;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;
    bit                 typed;
    out_item_t          want;
  } row_t;

  localparam out_item_t NO_RESULT = '0;
  localparam out_item_t REFILL_S0 = '{1'b1, 4'd0, 1'b0, 64'd0, 64'd0, 1'b0, 1'b0};
  localparam out_item_t LAST_PAIR = '{1'b0, 4'd0, 1'b1, KMAX, 64'd5, 1'b1, 1'b0};

  localparam int DIR_ROWS = 29;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    // source 1 has no head yet, so nothing can be taken
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, 64'd0, 1'b1, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd2, KMAX, KMAX, 1'b1, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, KMAX, 64'd1, 1'b1, NO_RESULT},
    // tie on key zero goes to source 0
    '{ROW_ITEM, '0, OP_PAIR, 4'd1, 64'd0, KMAX, 1'b1, REFILL_S0},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, KMAX, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd1, 64'd1, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd1, KMAX, 64'd5, 1'b0, NO_RESULT},
    // step back below the pending key
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, 64'd7, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_REDUCE_OP, OP_PAIR, 4'd0, 64'(ROP_MIN), 64'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, 64'd3, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_REDUCE_OP, OP_PAIR, 4'd0, 64'(ROP_MAX), 64'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, 64'd9, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_REDUCE_OP, OP_PAIR, 4'd0, 64'(ROP_OR), 64'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, 64'd6, 1'b0, NO_RESULT},
    // upper data bits must be dropped: this selects add
    '{ROW_CFG, CFG_REDUCE_OP, OP_PAIR, 4'd0, 64'hFFFF_FFFC, 64'd0, 1'b0, NO_RESULT},
    '{ROW_CFG, 8'hA5, OP_PAIR, 4'd0, 64'h1234_5677, 64'd0, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_SOURCES_IN_USE, OP_PAIR, 4'd0, 64'd1, 64'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd1, 64'd5, 64'd5, 1'b1, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd0, 64'd1, 1'b0, NO_RESULT},
    // zero live sources behaves as one
    '{ROW_CFG, CFG_SOURCES_IN_USE, OP_PAIR, 4'd0, 64'd0, 64'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd2, 64'd2, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_SOURCES_IN_USE, OP_PAIR, 4'd0, 64'd2, 64'd0, 1'b0, NO_RESULT},
    // end while holding a head, repeat it, then deliver to the ended source
    '{ROW_ITEM, '0, OP_END, 4'd1, 64'd0, 64'd0, 1'b1, NO_RESULT},
    '{ROW_ITEM, '0, OP_END, 4'd1, KMAX, KMAX, 1'b1, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd1, 64'd3, 64'd3, 1'b1, NO_RESULT},
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd4, 64'd4, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_END, 4'd0, 64'd0, 64'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, OP_END, 4'd0, 64'd0, 64'd0, 1'b1, LAST_PAIR},
    // all ended, nothing pending
    '{ROW_ITEM, '0, OP_PAIR, 4'd0, 64'd1, 64'd1, 1'b1, NO_RESULT}
  };

  localparam logic [SIU_W-1:0] PHASE_NSRC [9] = '{5'd16, 5'd5, 5'd31, 5'd3, 5'd9,
                                                  5'd17, 5'd12, 5'd16, 5'd16};
  localparam logic [ROP_W-1:0] PHASE_ROP [9] = '{ROP_ADD, ROP_MIN, ROP_MAX, ROP_OR, ROP_ADD,
                                                 ROP_MIN, ROP_MAX, ROP_OR, ROP_ADD};

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = OP_PAIR;
  logic [SRC_W-1:0]      in_source = '0;
  logic [FIELD_W-1:0]    in_key = '0;
  logic [FIELD_W-1:0]    in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_refill_valid;
  logic [SRC_W-1:0]      out_refill_source;
  logic                  out_pair_valid;
  logic [FIELD_W-1:0]    out_pair_key;
  logic [FIELD_W-1:0]    out_pair_value;
  logic                  out_pair_last;
  logic                  out_order_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  k_way_merge_reduce_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_source, .in_key, .in_value,
    .out_valid, .out_ready, .out_refill_valid, .out_refill_source, .out_pair_valid,
    .out_pair_key, .out_pair_value, .out_pair_last, .out_order_error,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  // model state of the merge
  logic [FIELD_W-1:0] hd_key [NSRC];
  logic [FIELD_W-1:0] hd_val [NSRC];
  bit                 hd_vld [NSRC];
  bit                 src_done [NSRC];
  logic [FIELD_W-1:0] pend_key, pend_val;
  bit                 pend_vld;
  logic [SIU_W-1:0]   cfg_nsrc = SIU_RESET;
  logic [ROP_W-1:0]   cfg_rop = ROP_ADD;

  logic [FIELD_W-1:0] src_next_key [NSRC];
  out_item_t          merge_outcomes [$];

  int send_idle_pct = 10;
  int recv_idle_pct = 52;
  int n_errors = 0;
  int n_results = 0;
  int n_accepted = 0;
  int n_pairs = 0;
  int n_order_err = 0;
  int n_last = 0;
  int n_refill = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d results still outstanding", merge_outcomes.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned live_sources();
    if (cfg_nsrc == 0) return 1;
    if (cfg_nsrc > NSRC) return NSRC;
    return cfg_nsrc;
  endfunction

  function automatic logic [FIELD_W-1:0] fold_value(logic [FIELD_W-1:0] a,
                                                    logic [FIELD_W-1:0] b);
    case (cfg_rop)
      ROP_ADD: return a + b;
      ROP_MIN: return (a < b) ? a : b;
      ROP_MAX: return (a > b) ? a : b;
      default: return a | b;
    endcase
  endfunction

  function automatic out_item_t step_merge(in_item_t rq);
    out_item_t res;
    int unsigned live, pick, i;
    bit all_ready, found;
    logic [FIELD_W-1:0] tk, tv;
    res = '0;
    live = live_sources();
    if (rq.source < live) begin
      if (rq.opcode == OP_END) begin
        src_done[rq.source] = 1'b1;
      end else if (!src_done[rq.source] && !hd_vld[rq.source]) begin
        hd_key[rq.source] = rq.key;
        hd_val[rq.source] = rq.value;
        hd_vld[rq.source] = 1'b1;
      end
    end
    all_ready = 1'b1;
    found = 1'b0;
    pick = 0;
    for (i = 0; i < live; i++) begin
      if (!hd_vld[i] && !src_done[i]) all_ready = 1'b0;
      if (hd_vld[i] && (!found || hd_key[i] < hd_key[pick])) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (!all_ready) return res;
    if (found) begin
      tk = hd_key[pick];
      tv = hd_val[pick];
      hd_vld[pick] = 1'b0;
      if (!src_done[pick]) begin
        res.refill_valid = 1'b1;
        res.refill_source = SRC_W'(pick);
      end
      if (pend_vld && tk == pend_key) begin
        pend_val = fold_value(pend_val, tv);
      end else begin
        if (pend_vld) begin
          res.pair_valid = 1'b1;
          res.pair_key = pend_key;
          res.pair_value = pend_val;
          res.order_error = (tk < pend_key);
        end
        pend_key = tk;
        pend_val = tv;
        pend_vld = 1'b1;
      end
    end else if (pend_vld) begin
      res.pair_valid = 1'b1;
      res.pair_key = pend_key;
      res.pair_value = pend_val;
      res.pair_last = 1'b1;
      pend_vld = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= 40) $display("ERROR at %0t, result %0d: %s", $time, n_results, what);
  endtask

  task automatic send_request(input logic op, input logic [SRC_W-1:0] src,
                              input logic [FIELD_W-1:0] k, input logic [FIELD_W-1:0] v,
                              input bit typed, input out_item_t want);
    out_item_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_source <= src;
    in_key    <= k;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
    res = step_merge('{op, src, k, v});
    merge_outcomes = {merge_outcomes, (typed ? want : res)};
    n_accepted++;
  endtask

  // drop the input request and let every result drain before touching a register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (merge_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SOURCES_IN_USE) cfg_nsrc = data[SIU_W-1:0];
    else if (idx == CFG_REDUCE_OP) cfg_rop = data[ROP_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // mostly refills of the sources that are short a head, with keys that mostly rise
  task automatic pick_request(input bit drain, output logic op, output logic [SRC_W-1:0] src,
                              output logic [FIELD_W-1:0] k, output logic [FIELD_W-1:0] v,
                              output bit counts);
    int unsigned live, r, i;
    int needy [$];
    int open [$];
    int closed [$];
    int held [$];
    live = live_sources();
    for (i = 0; i < live; i++) begin
      if (!src_done[i] && !hd_vld[i]) needy = {needy, int'(i)};
      if (!src_done[i]) open = {open, int'(i)};
      else closed = {closed, int'(i)};
      if (hd_vld[i] && !src_done[i]) held = {held, int'(i)};
    end
    v = {$urandom, $urandom};
    k = {$urandom, $urandom};
    src = SRC_W'($urandom_range(0, NSRC - 1));
    op = OP_PAIR;
    counts = (open.size() == 0);
    r = $urandom_range(0, 99);
    if (drain && open.size() != 0 && r < 10) begin
      op = OP_END;
      src = SRC_W'(open[$urandom_range(0, open.size() - 1)]);
      counts = 1'b1;
    end else if (needy.size() != 0 && r < 85) begin
      src = SRC_W'(needy[$urandom_range(0, needy.size() - 1)]);
      k = src_next_key[src];
      case ($urandom_range(0, 39))
        0: k = k - $urandom_range(1, 4);
        1: k = {$urandom, $urandom};
        default: k = k + $urandom_range(0, 2);
      endcase
      src_next_key[src] = k;
      counts = 1'b1;
    end else begin
      case ($urandom_range(0, 3))
        0: if (live < NSRC) src = SRC_W'($urandom_range(live, NSRC - 1));
        1: if (closed.size() != 0) begin
          op = OP_END;
          src = SRC_W'(closed[$urandom_range(0, closed.size() - 1)]);
        end
        2: if (held.size() != 0) src = SRC_W'(held[$urandom_range(0, held.size() - 1)]);
        default: ;
      endcase
    end
  endtask

  // result side: random back-pressure and in-order compare
  initial begin
    out_item_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        n_results++;
        got = '{out_refill_valid, out_refill_source, out_pair_valid, out_pair_key,
                out_pair_value, out_pair_last, out_order_error};
        if (merge_outcomes.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = merge_outcomes.pop_front();
          n_pairs += want.pair_valid;
          n_order_err += want.order_error;
          n_last += want.pair_last;
          n_refill += want.refill_valid;
          if (got.refill_valid !== want.refill_valid)
            report_mismatch($sformatf("refill_valid expected %b got %b",
                                      want.refill_valid, got.refill_valid));
          if (got.refill_source !== want.refill_source)
            report_mismatch($sformatf("refill_source expected %0d got %0d",
                                      want.refill_source, got.refill_source));
          if (got.pair_valid !== want.pair_valid)
            report_mismatch($sformatf("pair_valid expected %b got %b",
                                      want.pair_valid, got.pair_valid));
          if (got.pair_key !== want.pair_key)
            report_mismatch($sformatf("pair_key expected %h got %h",
                                      want.pair_key, got.pair_key));
          if (got.pair_value !== want.pair_value)
            report_mismatch($sformatf("pair_value expected %h got %h",
                                      want.pair_value, got.pair_value));
          if (got.pair_last !== want.pair_last)
            report_mismatch($sformatf("pair_last expected %b got %b",
                                      want.pair_last, got.pair_last));
          if (got.order_error !== want.order_error)
            report_mismatch($sformatf("order_error expected %b got %b",
                                      want.order_error, got.order_error));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    logic op;
    logic [SRC_W-1:0] src;
    logic [FIELD_W-1:0] k, v, base;
    logic [CFG_DATA_W-1:0] d;
    bit counts, drain;
    int mode, ph, p, good, s;
    for (s = 0; s < NSRC; s++) begin
      hd_vld[s] = 1'b0;
      src_done[s] = 1'b0;
    end
    pend_vld = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG)
        write_reg(DIRECTED[r].idx, DIRECTED[r].key[CFG_DATA_W-1:0]);
      else
        send_request(DIRECTED[r].opcode, DIRECTED[r].source, DIRECTED[r].key,
                     DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 52 : 0;
      recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 10 : 0;
      for (ph = 0; ph < 3; ph++) begin
        p = mode * 3 + ph;
        // random upper bits on the write data must be ignored
        d = $urandom;
        d[SIU_W-1:0] = PHASE_NSRC[p];
        write_reg(CFG_SOURCES_IN_USE, d);
        d = $urandom;
        d[ROP_W-1:0] = PHASE_ROP[p];
        write_reg(CFG_REDUCE_OP, d);
        case ($urandom_range(0, 2))
          0: base = '0;
          1: base = KMAX - 64'd300;
          default: base = {$urandom, $urandom};
        endcase
        for (s = 0; s < NSRC; s++) src_next_key[s] = base;
        // in the last phase requests may also end sources, so a final pair can get flagged
        drain = (p == 8);
        good = 0;
        while (good < PHASE_ITEMS) begin
          pick_request(drain, op, src, k, v, counts);
          send_request(op, src, k, v, 1'b0, NO_RESULT);
          good += counts;
        end
      end
    end

    in_valid <= 1'b0;
    while (merge_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Merged %0d requests over 9 config phases and 3 handshake mixes", n_accepted);
    $display("Saw %0d results: %0d refills, %0d pairs, %0d order errors, %0d final pairs",
             n_results, n_refill, n_pairs, n_order_err, n_last);
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
